// ===== rtl/rtrp_pkg.sv =====
`default_nettype none
package rtrp_pkg;

  typedef enum logic [2:0] {
    KIND_DATA     = 3'd0,
    KIND_RESOURCE = 3'd1,
    KIND_TEXT_OK  = 3'd2,
    KIND_NO_MARK  = 3'd3,
    KIND_BAD      = 3'd4
  } kind_t;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  // one front-end decision: up to three bytes, then a record or a stop
  typedef struct packed {
    logic [1:0]  nbytes;
    logic [23:0] data;
    logic        rec;
    logic [5:0]  type_id;
    logic [9:0]  qualifier;
    logic [15:0] resource_id;
    logic [30:0] length;
    logic        is_stop;
    kind_t       stop_kind;
  } job_t;

endpackage
`default_nettype wire

// ===== rtl/rtrp_front.sv =====
`default_nettype none
module rtrp_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [7:0]    ch,
  input  wire logic          end_of_input,
  input  wire logic          accept,
  output rtrp_pkg::job_t     job,
  output logic               job_push
);
  import rtrp_pkg::*;

  typedef enum logic [2:0] {
    MODE_SEARCH,
    MODE_TAG,
    MODE_IDLE,
    MODE_DIGITS,
    MODE_OPEN,
    MODE_BODY,
    MODE_STOPPED
  } mode_t;

  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_Q     = 8'h71;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [3:0] MARKER_LEN = 4'd9;

  localparam logic [16:0] TYPE_LIMIT = 17'h00040;
  localparam logic [16:0] QUAL_LIMIT = 17'h00400;
  localparam logic [16:0] ID_LIMIT   = 17'h10000;

  function automatic logic [7:0] marker_char(input logic [3:0] pos);
    logic [7:0] c;
    unique case (pos)
      4'd0:    c = 8'h3c;
      4'd1:    c = 8'h65;
      4'd2:    c = 8'h67;
      4'd3:    c = 8'h67;
      4'd4:    c = 8'h2d;
      4'd5:    c = 8'h72;
      4'd6:    c = 8'h6f;
      4'd7:    c = 8'h6d;
      4'd8:    c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      r = {1'b1, c[3:0] + 4'd9};
    else r = 5'd0;
    return r;
  endfunction

  function automatic logic [6:0] b64_val(input logic [7:0] c);
    logic [6:0] r;
    if (c >= 8'h41 && c <= 8'h5a) r = {1'b1, c[5:0] - 6'd1};
    else if (c >= 8'h61 && c <= 8'h7a) r = {1'b1, c[5:0] - 6'd7};
    else if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[5:0] + 6'd4};
    else if (c == 8'h2b) r = {1'b1, 6'd62};
    else if (c == 8'h2f) r = {1'b1, 6'd63};
    else r = 7'd0;
    return r;
  endfunction

  function automatic logic [16:0] sat_add(input logic [16:0] base, input logic [31:0] arg,
                                          input logic [16:0] limit);
    logic [33:0] v;
    v = {17'd0, base} + {2'd0, arg} + 34'd1;
    return (v > {17'd0, limit}) ? limit : v[16:0];
  endfunction

  mode_t       mode_r, mode_nxt;
  logic [3:0]  mpos_r, mpos_nxt;
  logic [6:0]  type_r, type_nxt;
  logic [10:0] qual_r, qual_nxt;
  logic [16:0] id_r, id_nxt;
  logic [31:0] arg_r, arg_nxt;
  logic [3:0]  dcnt_r, dcnt_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [17:0] grp_r, grp_nxt;
  logic [1:0]  fill_r, fill_nxt;
  logic [30:0] emit_r, emit_nxt;

  logic [16:0] sat_t, sat_q, sat_s;
  logic [4:0]  hx;
  logic [6:0]  bx;
  logic [30:0] rem;
  logic [1:0]  nb;
  logic        go;
  logic        bad_r_cmd;
  logic [23:0] grp_word;

  assign sat_t = sat_add({10'd0, type_r}, arg_r, TYPE_LIMIT);
  assign sat_q = sat_add({6'd0, qual_r}, arg_r, QUAL_LIMIT);
  assign sat_s = sat_add(id_r, arg_r, ID_LIMIT);
  assign hx    = hex_val(ch);
  assign bx    = b64_val(ch);
  assign rem   = arg_r[30:0] - emit_r;
  assign nb    = (rem >= 31'd3) ? 2'd3 : rem[1:0];
  assign bad_r_cmd = arg_r[31] || (type_r > 7'h3f) || (qual_r > 11'h3ff) ||
                     (id_r > 17'h0ffff);

  always_comb begin
    unique case (fill_r)
      2'd1:    grp_word = {grp_r[5:0], 18'd0};
      2'd2:    grp_word = {grp_r[11:0], 12'd0};
      2'd3:    grp_word = {grp_r[17:0], 6'd0};
      default: grp_word = 24'd0;
    endcase
  end

  always_comb begin
    mode_nxt = mode_r;
    mpos_nxt = mpos_r;
    type_nxt = type_r;
    qual_nxt = qual_r;
    id_nxt   = id_r;
    arg_nxt  = arg_r;
    dcnt_nxt = dcnt_r;
    cmd_nxt  = cmd_r;
    grp_nxt  = grp_r;
    fill_nxt = fill_r;
    emit_nxt = emit_r;
    job      = '0;
    job.stop_kind = KIND_BAD;
    go       = 1'b0;

    if (mode_r == MODE_STOPPED) begin
      go = 1'b0;
    end else if (end_of_input) begin
      job.is_stop   = 1'b1;
      job.stop_kind = (mode_r == MODE_SEARCH) ? KIND_NO_MARK : KIND_BAD;
      mode_nxt      = MODE_STOPPED;
    end else if (mode_r == MODE_SEARCH) begin
      if (mpos_r < MARKER_LEN && ch == marker_char(mpos_r)) begin
        if (mpos_r == MARKER_LEN - 4'd1) begin
          mpos_nxt = 4'd0;
          mode_nxt = MODE_TAG;
        end else begin
          mpos_nxt = mpos_r + 4'd1;
        end
      end else begin
        mpos_nxt = (ch == CH_LT) ? 4'd1 : 4'd0;
      end
    end else if (mode_r == MODE_TAG) begin
      if (ch == CH_GT) mode_nxt = MODE_IDLE;
    end else begin
      go = 1'b1;
      if (mode_r == MODE_DIGITS) begin
        if (hx[4]) begin
          go = 1'b0;
          if (dcnt_r >= 4'd8) begin
            job.is_stop = 1'b1;
            mode_nxt    = MODE_STOPPED;
          end else begin
            arg_nxt  = {arg_r[27:0], hx[3:0]};
            dcnt_nxt = dcnt_r + 4'd1;
          end
        end else if (dcnt_r == 4'd0) begin
          go          = 1'b0;
          job.is_stop = 1'b1;
          mode_nxt    = MODE_STOPPED;
        end else begin
          // the terminating character is processed after the command takes effect
          unique case (cmd_r)
            CH_T: begin
              type_nxt = sat_t[6:0];
              qual_nxt = 11'd0;
              id_nxt   = 17'd1;
              mode_nxt = MODE_IDLE;
            end
            CH_Q: begin
              qual_nxt = sat_q[10:0];
              id_nxt   = 17'd1;
              mode_nxt = MODE_IDLE;
            end
            CH_S: begin
              id_nxt   = sat_s;
              mode_nxt = MODE_IDLE;
            end
            CH_R: begin
              if (bad_r_cmd) begin
                go          = 1'b0;
                job.is_stop = 1'b1;
                mode_nxt    = MODE_STOPPED;
              end else begin
                mode_nxt = MODE_OPEN;
              end
            end
            default: begin
              go          = 1'b0;
              job.is_stop = 1'b1;
              mode_nxt    = MODE_STOPPED;
            end
          endcase
        end
      end

      if (go) begin
        if (mode_nxt == MODE_IDLE) begin
          if (ch <= CH_SPACE) begin
            go = 1'b1;
          end else if (ch == CH_LT) begin
            job.is_stop   = 1'b1;
            job.stop_kind = KIND_TEXT_OK;
            mode_nxt      = MODE_STOPPED;
          end else begin
            cmd_nxt  = ch;
            arg_nxt  = 32'd0;
            dcnt_nxt = 4'd0;
            mode_nxt = MODE_DIGITS;
          end
        end else if (mode_nxt == MODE_OPEN) begin
          if (ch <= CH_SPACE) begin
            go = 1'b1;
          end else if (ch == CH_LPAR) begin
            grp_nxt  = 18'd0;
            fill_nxt = 2'd0;
            emit_nxt = 31'd0;
            mode_nxt = MODE_BODY;
          end else begin
            job.is_stop = 1'b1;
            mode_nxt    = MODE_STOPPED;
          end
        end else if (mode_nxt == MODE_BODY) begin
          if (ch == CH_RPAR) begin
            // partial group is padded with zero sextets
            if (fill_r != 2'd0) begin
              job.nbytes = nb;
              job.data   = grp_word;
              emit_nxt   = emit_r + {29'd0, nb};
            end
            job.rec         = 1'b1;
            job.type_id     = type_r[5:0];
            job.qualifier   = qual_r[9:0];
            job.resource_id = id_r[15:0];
            job.length      = arg_r[30:0];
            grp_nxt  = 18'd0;
            fill_nxt = 2'd0;
            id_nxt   = (id_r >= ID_LIMIT) ? ID_LIMIT : id_r + 17'd1;
            mode_nxt = MODE_IDLE;
          end else if (ch > CH_SPACE) begin
            if (!bx[6]) begin
              job.is_stop = 1'b1;
              mode_nxt    = MODE_STOPPED;
            end else if (fill_r == 2'd3) begin
              job.nbytes = nb;
              job.data   = {grp_r, bx[5:0]};
              emit_nxt   = emit_r + {29'd0, nb};
              grp_nxt    = 18'd0;
              fill_nxt   = 2'd0;
            end else begin
              grp_nxt  = {grp_r[11:0], bx[5:0]};
              fill_nxt = fill_r + 2'd1;
            end
          end
        end
      end
    end
  end

  assign job_push = accept && (job.nbytes != 2'd0 || job.rec || job.is_stop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_SEARCH;
      mpos_r <= 4'd0;
      type_r <= 7'd1;
      qual_r <= 11'd0;
      id_r   <= 17'd1;
      arg_r  <= 32'd0;
      dcnt_r <= 4'd0;
      cmd_r  <= 8'd0;
      grp_r  <= 18'd0;
      fill_r <= 2'd0;
      emit_r <= 31'd0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      mpos_r <= mpos_nxt;
      type_r <= type_nxt;
      qual_r <= qual_nxt;
      id_r   <= id_nxt;
      arg_r  <= arg_nxt;
      dcnt_r <= dcnt_nxt;
      cmd_r  <= cmd_nxt;
      grp_r  <= grp_nxt;
      fill_r <= fill_nxt;
      emit_r <= emit_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rtrp_queue.sv =====
`default_nettype none
module rtrp_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire rtrp_pkg::job_t wr_data,
  input  wire logic           pop,
  output rtrp_pkg::job_t      rd_data,
  output logic                full,
  output logic                empty
);
  import rtrp_pkg::*;

  localparam logic [QUEUE_AW-1:0] LAST_SLOT = QUEUE_AW'(QUEUE_DEPTH - 1);
  localparam logic [QUEUE_AW:0]   DEPTH_CNT = (QUEUE_AW + 1)'(QUEUE_DEPTH);

  job_t                slot_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_AW:0]   cnt_r;
  logic                do_push, do_pop;

  assign full    = (cnt_r == DEPTH_CNT);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rtrp_back.sv =====
`default_nettype none
module rtrp_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire rtrp_pkg::job_t q_data,
  input  wire logic          q_empty,
  output logic               q_pop,
  input  wire logic          out_pop,
  output logic               out_empty,
  output logic [2:0]         out_kind,
  output logic [7:0]         out_data_byte,
  output logic [5:0]         out_type_id,
  output logic [9:0]         out_qualifier,
  output logic [15:0]        out_resource_id,
  output logic [30:0]        out_length,
  output logic               out_last
);
  import rtrp_pkg::*;

  job_t  cur_r;
  logic  cur_vld_r;
  logic  has_byte, item_last, xfer, done, load;
  kind_t kind;

  assign has_byte = (cur_r.nbytes != 2'd0);

  always_comb begin
    if (has_byte) begin
      kind      = KIND_DATA;
      item_last = (cur_r.nbytes == 2'd1) && !cur_r.rec && !cur_r.is_stop;
    end else if (cur_r.rec) begin
      kind      = KIND_RESOURCE;
      item_last = !cur_r.is_stop;
    end else begin
      kind      = cur_r.stop_kind;
      item_last = 1'b1;
    end
  end

  assign xfer  = cur_vld_r && out_pop;
  assign done  = xfer && item_last;
  assign load  = (!cur_vld_r || done) && !q_empty;
  assign q_pop = load;

  assign out_empty       = !cur_vld_r;
  assign out_kind        = kind;
  assign out_last        = item_last;
  assign out_data_byte   = (kind == KIND_DATA) ? cur_r.data[23:16] : 8'd0;
  assign out_type_id     = (kind == KIND_RESOURCE) ? cur_r.type_id : 6'd0;
  assign out_qualifier   = (kind == KIND_RESOURCE) ? cur_r.qualifier : 10'd0;
  assign out_resource_id = (kind == KIND_RESOURCE) ? cur_r.resource_id : 16'd0;
  assign out_length      = (kind == KIND_RESOURCE) ? cur_r.length : 31'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
    end else if (load) begin
      cur_vld_r <= 1'b1;
    end else if (done) begin
      cur_vld_r <= 1'b0;
    end
  end

  // payload advances one result per transfer
  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= q_data;
    end else if (xfer && !done) begin
      if (has_byte) begin
        cur_r.nbytes <= cur_r.nbytes - 2'd1;
        cur_r.data   <= {cur_r.data[15:0], 8'd0};
      end else begin
        cur_r.rec <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rom_text_resource_parser_unit.sv =====
`default_nettype none
// Text resource parser: one character per transfer in, decoded bytes and records out.
// Input queue side: drive in_ch / in_end_of_input with in_push; a transfer happens
// when in_push is high and in_full is low. Result side: while out_empty is low the
// oldest result sits on the out_ ports; out_pop takes it.
// For each accepted character the parser front end decides up to three data bytes
// plus a resource record, or a terminal status, and writes that as one entry into
// a four-deep queue. The back end replays one result per cycle from the head entry
// while out_pop is high, so a character is accepted every cycle as long as the
// average number of results per character stays at or below one; a ')' that closes
// a partial group yields up to four results (three bytes and the record).
// A result is written into a queue entry and then loaded into the back-end register,
// once that is free, before it shows on the out_ ports.
// A stalled receiver first fills the back end and the queue; in_full then rises and
// holds off further characters without losing any state.
// Reset (rst_n low, synchronous) clears the queue, the back end and all parser
// counters; the parser restarts its marker search.
// After a terminal status (ok, marker not found, malformed) nothing more comes out
// until reset.
module rom_text_resource_parser_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [7:0]  in_ch,
  input  wire logic        in_end_of_input,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [2:0]       out_kind,
  output logic [7:0]       out_data_byte,
  output logic [5:0]       out_type_id,
  output logic [9:0]       out_qualifier,
  output logic [15:0]      out_resource_id,
  output logic [30:0]      out_length,
  output logic             out_last
);
  import rtrp_pkg::*;

  job_t fe_job, q_head;
  logic fe_push, q_full, q_empty, q_pop, accept;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  rtrp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .ch           (in_ch),
    .end_of_input (in_end_of_input),
    .accept       (accept),
    .job          (fe_job),
    .job_push     (fe_push)
  );

  rtrp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (fe_push),
    .wr_data (fe_job),
    .pop     (q_pop),
    .rd_data (q_head),
    .full    (q_full),
    .empty   (q_empty)
  );

  rtrp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_data          (q_head),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .out_pop         (out_pop),
    .out_empty       (out_empty),
    .out_kind        (out_kind),
    .out_data_byte   (out_data_byte),
    .out_type_id     (out_type_id),
    .out_qualifier   (out_qualifier),
    .out_resource_id (out_resource_id),
    .out_length      (out_length),
    .out_last        (out_last)
  );

endmodule
`default_nettype wire

// ===== dv/rom_text_resource_parser_unit_test.sv =====
`default_nettype none
module rom_text_resource_parser_unit_test;
  import rtrp_pkg::*;

  localparam int N_ITEMS     = 480;
  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_CYCLES = 150;
  localparam int DRAIN_WAIT  = 20;

  // opening marker, one byte per position, first byte in the top bits
  localparam logic [71:0] OPEN_TAG = 72'h3c_65_67_67_2d_72_6f_6d_20;

  localparam logic [7:0] CMD_TYPE  = "t";
  localparam logic [7:0] CMD_QUAL  = "q";
  localparam logic [7:0] CMD_SEQ   = "s";
  localparam logic [7:0] CMD_RES   = "r";
  localparam logic [7:0] CMD_WRONG = "w";
  localparam logic [7:0] CH_LT     = "<";
  localparam logic [7:0] CH_GT     = ">";
  localparam logic [7:0] CH_OPEN   = "(";
  localparam logic [7:0] CH_CLOSE  = ")";
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_EQUAL  = "=";

  typedef enum logic [2:0] {
    P_SEARCH, P_TAG, P_IDLE, P_DIGITS, P_OPEN, P_BODY, P_STOPPED
  } parse_mode_t;

  typedef enum int {
    END_OK, END_EOI_ARG, END_LONG_ARG, END_BAD_LETTER, END_HUGE_LEN,
    END_BAD_BODY, END_BAD_OPEN, END_EMPTY_ARG, END_TYPE_FULL, END_EOI_IDLE
  } text_ending_t;

  typedef struct {
    logic [7:0] ch;
    logic       eoi;
    bit         pause;
  } text_item_t;

  typedef struct {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [5:0]  type_id;
    logic [9:0]  qualifier;
    logic [15:0] resource_id;
    logic [30:0] length;
    logic        last;
  } parse_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [7:0]  in_ch = 8'h00;
  logic        in_end_of_input = 1'b0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [2:0]  out_kind;
  logic [7:0]  out_data_byte;
  logic [5:0]  out_type_id;
  logic [9:0]  out_qualifier;
  logic [15:0] out_resource_id;
  logic [30:0] out_length;
  logic        out_last;

  rom_text_resource_parser_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_ch           (in_ch),
    .in_end_of_input (in_end_of_input),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_kind        (out_kind),
    .out_data_byte   (out_data_byte),
    .out_type_id     (out_type_id),
    .out_qualifier   (out_qualifier),
    .out_resource_id (out_resource_id),
    .out_length      (out_length),
    .out_last        (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  text_item_t    text_q[$];
  parse_result_t expected_results[$];
  parse_result_t step_results[$];
  parse_result_t got_want;
  int            mismatches = 0;
  int            accepted_chars = 0;
  int            stall_cycles = 0;
  bit            char_taken = 0;
  bit            hold_rx = 0;
  bit            pause_next = 0;

  // parser state of the prediction
  parse_mode_t p_mode;
  logic [3:0]  p_mpos;
  logic [6:0]  p_type;
  logic [10:0] p_qual;
  logic [16:0] p_id;
  logic [31:0] p_arg;
  logic [3:0]  p_ndig;
  logic [7:0]  p_cmd;
  logic [17:0] p_group;
  logic [1:0]  p_fill;
  logic [30:0] p_emitted;

  // counters as the stimulus builder expects them to be
  logic [31:0] g_type = 32'd1;
  logic [31:0] g_qual = 32'd0;
  logic [31:0] g_id   = 32'd1;

  function automatic logic [7:0] tag_byte(int pos);
    return OPEN_TAG[71 - 8 * pos -: 8];
  endfunction

  function automatic logic [31:0] sat_count(logic [31:0] base, logic [31:0] arg,
                                            logic [31:0] limit);
    logic [33:0] v;
    v = 34'(base) + 34'(arg) + 34'd1;
    return (v > 34'(limit)) ? limit : v[31:0];
  endfunction

  function automatic int hex_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic int sextet_value(logic [7:0] c);
    if (c >= "A" && c <= "Z") return int'(c - "A");
    if (c >= "a" && c <= "z") return int'(c - "a") + 26;
    if (c >= "0" && c <= "9") return int'(c - "0") + 52;
    if (c == "+") return 62;
    if (c == "/") return 63;
    return -1;
  endfunction

  function automatic logic [7:0] sextet_char(int v);
    if (v < 26) return 8'("A" + v);
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    return (v == 62) ? 8'("+") : 8'("/");
  endfunction

  task automatic add_result(kind_t kind, logic [7:0] b);
    parse_result_t r;
    r.kind        = kind;
    r.data_byte   = (kind == KIND_DATA) ? b : 8'h00;
    r.type_id     = (kind == KIND_RESOURCE) ? p_type[5:0] : 6'h00;
    r.qualifier   = (kind == KIND_RESOURCE) ? p_qual[9:0] : 10'h000;
    r.resource_id = (kind == KIND_RESOURCE) ? p_id[15:0] : 16'h0000;
    r.length      = (kind == KIND_RESOURCE) ? p_arg[30:0] : 31'h0;
    r.last        = 1'b0;
    step_results.push_back(r);
  endtask

  task automatic stop_text(kind_t kind);
    add_result(kind, 8'h00);
    p_mode = P_STOPPED;
  endtask

  task automatic emit_bytes(logic [23:0] v);
    for (int k = 0; k < 3; k++) begin
      if (p_emitted < p_arg[30:0]) begin
        add_result(KIND_DATA, v[23 - 8 * k -: 8]);
        p_emitted++;
      end
    end
  endtask

  // closes the pending command, 0 when it was malformed
  function automatic bit close_command();
    case (p_cmd)
      CMD_TYPE: begin
        p_type = 7'(sat_count(32'(p_type), p_arg, 32'h40));
        p_qual = '0;
        p_id   = 17'd1;
        p_mode = P_IDLE;
        return 1'b1;
      end
      CMD_QUAL: begin
        p_qual = 11'(sat_count(32'(p_qual), p_arg, 32'h400));
        p_id   = 17'd1;
        p_mode = P_IDLE;
        return 1'b1;
      end
      CMD_SEQ: begin
        p_id   = 17'(sat_count(32'(p_id), p_arg, 32'h10000));
        p_mode = P_IDLE;
        return 1'b1;
      end
      CMD_RES: begin
        if (p_arg[31] || p_type > 7'h3f || p_qual > 11'h3ff || p_id > 17'hffff)
          return 1'b0;
        p_mode = P_OPEN;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic decode_char(logic [7:0] c, logic eoi);
    int d;
    int s;
    bit handled;
    step_results.delete();
    handled = 0;
    if (p_mode != P_STOPPED) begin
      if (eoi) begin
        stop_text((p_mode == P_SEARCH) ? KIND_NO_MARK : KIND_BAD);
      end else if (p_mode == P_SEARCH) begin
        if (p_mpos < 9 && c == tag_byte(int'(p_mpos))) begin
          p_mpos++;
          if (p_mpos == 9) begin
            p_mpos = '0;
            p_mode = P_TAG;
          end
        end else begin
          p_mpos = (c == CH_LT) ? 4'd1 : 4'd0;
        end
      end else if (p_mode == P_TAG) begin
        if (c == CH_GT) p_mode = P_IDLE;
      end else begin
        if (p_mode == P_DIGITS) begin
          d = hex_value(c);
          if (d >= 0) begin
            if (p_ndig >= 8) stop_text(KIND_BAD);
            else begin
              p_arg = {p_arg[27:0], 4'(d)};
              p_ndig++;
            end
            handled = 1;
          end else if (p_ndig == 0 || !close_command()) begin
            stop_text(KIND_BAD);
            handled = 1;
          end
        end
        if (!handled) begin
          case (p_mode)
            P_IDLE: begin
              if (c <= CH_SPACE) begin
              end else if (c == CH_LT) begin
                stop_text(KIND_TEXT_OK);
              end else begin
                p_cmd  = c;
                p_arg  = '0;
                p_ndig = '0;
                p_mode = P_DIGITS;
              end
            end
            P_OPEN: begin
              if (c <= CH_SPACE) begin
              end else if (c == CH_OPEN) begin
                p_group   = '0;
                p_fill    = '0;
                p_emitted = '0;
                p_mode    = P_BODY;
              end else begin
                stop_text(KIND_BAD);
              end
            end
            P_BODY: begin
              if (c == CH_CLOSE) begin
                // short group is padded with zero sextets
                if (p_fill != 0) emit_bytes(24'(p_group) << (6 * (4 - int'(p_fill))));
                p_group = '0;
                p_fill  = '0;
                add_result(KIND_RESOURCE, 8'h00);
                p_id   = 17'(sat_count(32'(p_id), 32'd0, 32'h10000));
                p_mode = P_IDLE;
              end else if (c > CH_SPACE) begin
                s = sextet_value(c);
                if (s < 0) begin
                  stop_text(KIND_BAD);
                end else if (p_fill == 3) begin
                  emit_bytes({p_group, 6'(s)});
                  p_group = '0;
                  p_fill  = '0;
                end else begin
                  p_group = {p_group[11:0], 6'(s)};
                  p_fill++;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
    end
    if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
    foreach (step_results[i]) expected_results.push_back(step_results[i]);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t on %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  // stimulus building
  task automatic add_char(logic [7:0] c);
    text_item_t it;
    it.ch    = c;
    it.eoi   = 1'b0;
    it.pause = pause_next;
    pause_next = 0;
    text_q.push_back(it);
  endtask

  task automatic add_eoi();
    text_item_t it;
    it.ch    = 8'($urandom);
    it.eoi   = 1'b1;
    it.pause = pause_next;
    pause_next = 0;
    text_q.push_back(it);
  endtask

  task automatic add_tag_prefix(int n);
    for (int i = 0; i < n; i++) add_char(tag_byte(i));
  endtask

  task automatic add_blank();
    repeat ($urandom_range(0, 2)) add_char(8'($urandom_range(0, 32)));
  endtask

  task automatic add_hex(logic [31:0] v, int ndig);
    logic [3:0] nib;
    for (int i = ndig - 1; i >= 0; i--) begin
      nib = v[4 * i +: 4];
      if (nib < 10) add_char(8'("0" + nib));
      else if ($urandom_range(0, 1) == 0) add_char(8'("a" + nib - 10));
      else add_char(8'("A" + nib - 10));
    end
  endtask

  task automatic add_command(logic [7:0] letter, logic [31:0] v);
    int sig;
    sig = 1;
    while (sig < 8 && (v >> (4 * sig)) != 0) sig++;
    add_char(letter);
    add_hex(v, $urandom_range(sig, 8));
    case (letter)
      CMD_TYPE: begin
        g_type = sat_count(g_type, v, 32'h40);
        g_qual = 0;
        g_id   = 1;
      end
      CMD_QUAL: begin
        g_qual = sat_count(g_qual, v, 32'h400);
        g_id   = 1;
      end
      CMD_SEQ: g_id = sat_count(g_id, v, 32'h10000);
      default: begin
      end
    endcase
    add_blank();
  endtask

  task automatic add_resource(logic [31:0] len, int nsym);
    // bring saturated counters back before the record
    if (g_id > 32'hffff || g_qual > 32'h3ff) begin
      if (g_qual < 32'h3ff) add_command(CMD_QUAL, 32'd0);
      else add_command(CMD_TYPE, 32'd0);
    end
    add_command(CMD_RES, len);
    add_char(CH_OPEN);
    repeat (nsym) begin
      if ($urandom_range(0, 5) == 0) add_char(8'($urandom_range(0, 32)));
      add_char(sextet_char($urandom_range(0, 63)));
    end
    add_char(CH_CLOSE);
    g_id = sat_count(g_id, 32'd0, 32'h10000);
  endtask

  task automatic build_text();
    logic [31:0] len;
    text_ending_t ending;
    // false start, then the marker, then tag contents up to '>'
    add_tag_prefix(3);
    add_tag_prefix(9);
    add_char(8'hff);
    add_char(8'h00);
    add_char(CH_GT);
    add_char(8'h00);
    // three bytes fit and a padded pair fills them: four results on one char
    add_command(CMD_RES, 32'd3);
    add_char(CH_OPEN);
    add_char(sextet_char(63));
    add_char(sextet_char(63));
    add_char(CH_CLOSE);
    // largest length: a full group, then a lone sextet
    add_command(CMD_RES, 32'h7fffffff);
    add_char(CH_OPEN);
    add_char(sextet_char(0));
    add_char(sextet_char(51));
    add_char(sextet_char(52));
    add_char(sextet_char(61));
    add_char(sextet_char(62));
    add_char(CH_CLOSE);
    g_id = 3;

    pause_next = 1;
    while (text_q.size() < N_ITEMS - 30) begin
      case ($urandom_range(0, 9))
        0: if (g_type < 40) add_command(CMD_TYPE, $urandom_range(0, 3));
        1: begin
          if ($urandom_range(0, 7) == 0 && g_type < 40) begin
            // argument far past the limit only saturates
            add_command(CMD_QUAL, $urandom_range(0, 1) ? 32'hffffffff : $urandom);
            add_command(CMD_TYPE, 32'd0);
          end else begin
            add_command(CMD_QUAL, $urandom_range(0, 15));
          end
        end
        2: begin
          if ($urandom_range(0, 7) == 0) add_command(CMD_SEQ, $urandom | 32'hffff0000);
          else add_command(CMD_SEQ, $urandom_range(0, 300));
        end
        default: begin
          case ($urandom_range(0, 19))
            0, 1:    len = 32'd0;
            2:       len = 32'h7fffffff;
            3, 4:    len = $urandom & 32'h7fffffff;
            default: len = $urandom_range(1, 12);
          endcase
          add_resource(len, ($urandom_range(0, 9) == 0) ? $urandom_range(13, 24)
                                                         : $urandom_range(0, 12));
        end
      endcase
    end

    pause_next = 1;
    ending = text_ending_t'($urandom_range(0, 9));
    case (ending)
      END_OK: begin
        add_blank();
        add_char(CH_LT);
      end
      END_EOI_ARG: begin
        add_char(CMD_SEQ);
        add_hex($urandom, 2);
        add_eoi();
      end
      END_LONG_ARG: begin
        add_char(CMD_SEQ);
        add_hex($urandom, 8);
        add_hex($urandom, 1);
      end
      END_BAD_LETTER: begin
        add_char(CMD_WRONG);
        add_hex($urandom, 3);
        add_char(CH_SPACE);
      end
      END_HUGE_LEN: begin
        add_command(CMD_RES, $urandom | 32'h80000000);
        add_char(CH_OPEN);
      end
      END_BAD_BODY: begin
        add_command(CMD_RES, 32'd2);
        add_char(CH_OPEN);
        add_char(sextet_char(7));
        add_char(CH_EQUAL);
      end
      END_BAD_OPEN: begin
        add_command(CMD_RES, 32'd2);
        add_char(CH_SPACE);
        add_char(sextet_char(49));
      end
      END_EMPTY_ARG: begin
        add_char(CMD_QUAL);
        add_char(CH_SPACE);
      end
      END_TYPE_FULL: begin
        add_command(CMD_TYPE, 32'hffffffff);
        add_command(CMD_RES, 32'd1);
        add_char(CH_OPEN);
      end
      default: add_eoi();
    endcase
    // nothing may come out after the final status
    repeat (3) add_char(8'($urandom));
    add_eoi();
  endtask

  function automatic int pick_odds();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 4;
      default: return 16;
    endcase
  endfunction

  function automatic bit winding_down();
    return text_q.size() < 60;
  endfunction

  // sender
  int tx_idle = 0;
  int tx_odds = 0;
  int tx_cycle = 0;
  bit tx_offer;

  always @(negedge clk) begin
    if (char_taken) begin
      void'(text_q.pop_front());
      char_taken = 0;
    end
    if (tx_cycle % 64 == 0) tx_odds = pick_odds();
    tx_cycle++;
    if (!rst_n || text_q.size() == 0) begin
      tx_offer = 0;
    end else if (text_q[0].pause && expected_results.size() != 0) begin
      tx_offer = 0;
    end else if (tx_idle > 0 && !winding_down()) begin
      tx_idle--;
      tx_offer = 0;
    end else if (!winding_down() && !hold_rx && tx_odds != 0 &&
                 $urandom_range(1, tx_odds) == 1) begin
      tx_idle  = $urandom_range(0, 8);
      tx_offer = 0;
    end else begin
      tx_offer = 1;
    end
    in_push <= tx_offer;
    if (tx_offer) begin
      in_ch           <= text_q[0].ch;
      in_end_of_input <= text_q[0].eoi;
    end
  end

  // receiver
  int rx_idle = 0;
  int rx_odds = 0;
  int rx_cycle = 0;
  bit rx_take;

  always @(negedge clk) begin
    if (rx_cycle % 64 == 0) rx_odds = pick_odds();
    rx_cycle++;
    if (!rst_n || hold_rx) begin
      rx_take = 0;
    end else if (rx_idle > 0 && !winding_down()) begin
      rx_idle--;
      rx_take = 0;
    end else if (!winding_down() && rx_odds != 0 && $urandom_range(1, rx_odds) == 1) begin
      rx_idle = $urandom_range(0, 8);
      rx_take = 0;
    end else begin
      rx_take = 1;
    end
    out_pop <= rx_take;
  end

  // monitor: predict on each input transfer, check each result transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) begin
        decode_char(in_ch, in_end_of_input);
        char_taken = 1;
        accepted_chars++;
      end
      if (out_pop && !out_empty) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, kind", 32'(out_kind), 32'h0);
        end else begin
          got_want = expected_results.pop_front();
          if (out_kind !== got_want.kind)
            report_mismatch("kind", 32'(out_kind), 32'(got_want.kind));
          if (out_data_byte !== got_want.data_byte)
            report_mismatch("data_byte", 32'(out_data_byte), 32'(got_want.data_byte));
          if (out_type_id !== got_want.type_id)
            report_mismatch("type_id", 32'(out_type_id), 32'(got_want.type_id));
          if (out_qualifier !== got_want.qualifier)
            report_mismatch("qualifier", 32'(out_qualifier), 32'(got_want.qualifier));
          if (out_resource_id !== got_want.resource_id)
            report_mismatch("resource_id", 32'(out_resource_id),
                            32'(got_want.resource_id));
          if (out_length !== got_want.length)
            report_mismatch("length", 32'(out_length), 32'(got_want.length));
          if (out_last !== got_want.last)
            report_mismatch("last", 32'(out_last), 32'(got_want.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("** rom_text_resource_parser_unit: FAILED **");
      $finish;
    end
  end

  // long receiver stall while characters keep coming, so in_full must rise
  initial begin
    while (accepted_chars < 200) @(posedge clk);
    hold_rx = 1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx = 0;
  end

  initial begin
    p_mode    = P_SEARCH;
    p_mpos    = '0;
    p_type    = 7'd1;
    p_qual    = '0;
    p_id      = 17'd1;
    p_arg     = '0;
    p_ndig    = '0;
    p_cmd     = '0;
    p_group   = '0;
    p_fill    = '0;
    p_emitted = '0;
    build_text();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (text_q.size() != 0) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("** rom_text_resource_parser_unit: PASSED **");
    end else begin
      $display("** rom_text_resource_parser_unit: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
